// ===== rtl/cfs_pkg.sv =====
// shared constants and types of the charge fault supervisor
package cfs_pkg;

  // width of the stored current level
  localparam int LEVEL_BITS = 4;

  // apb address width: eight registers at byte address 4*i
  localparam int ADDR_BITS = 5;

  // register indexes
  localparam logic [2:0] REG_OVERVOLT_LIMIT  = 3'd0;
  localparam logic [2:0] REG_UNDERVOLT_LIMIT = 3'd1;
  localparam logic [2:0] REG_VOLT_MARGIN     = 3'd2;
  localparam logic [2:0] REG_PERSIST_TICKS   = 3'd3;
  localparam logic [2:0] REG_TEMP_TRIP       = 3'd4;
  localparam logic [2:0] REG_TEMP_DERATE     = 3'd5;
  localparam logic [2:0] REG_TEMP_RESTORE    = 3'd6;
  localparam logic [2:0] REG_BASE_LEVEL      = 3'd7;

  // register reset values
  localparam logic [8:0]        OVERVOLT_RST  = 9'd265;
  localparam logic [8:0]        UNDERVOLT_RST = 9'd100;
  localparam logic [4:0]        MARGIN_RST    = 5'd2;
  localparam logic [15:0]       PERSIST_RST   = 16'd5000;
  localparam logic signed [8:0] TEMP_TRIP_RST    = 9'sd80;
  localparam logic signed [8:0] TEMP_DERATE_RST  = 9'sd75;
  localparam logic signed [8:0] TEMP_RESTORE_RST = 9'sd70;
  localparam logic [3:0]        BASE_LEVEL_RST   = 4'd0;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_TEMP  = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_UNDER = 2'd3
  } fault_t;

  // fault flag codes
  typedef enum logic [1:0] {
    FLAG_CLEAR   = 2'd0,
    FLAG_PENDING = 2'd1,
    FLAG_LATCHED = 2'd2
  } flag_t;

  // fault timer width, saturating at all ones
  localparam int TIMER_BITS = 17;

endpackage

// ===== rtl/charge_fault_supervisor.sv =====
// charge fault supervisor: temperature and mains voltage protection per tick
// a tick transaction passes the input register, then the result register, on its way to the result port
// throughput: one tick transaction per cycle, limited only by result port stalls
// the state update for a tick is one pass of compare logic from the input register
// reset: synchronous, clears the pipeline, the supervisor state and loads register defaults
module charge_fault_supervisor (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // tick input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [8:0]                    mains_volts,
  input  logic signed [8:0]             temp_celsius,
  input  logic                          temp_check,
  input  logic                          system_ready,
  input  logic                          start_charge,
  input  logic                          stop_charge,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    work_state,
  output logic                          relay_open_cmd,
  output logic                          relay_close_cmd,
  output logic                          pwm_enabled,
  output logic [3:0]                    current_level,
  output logic [1:0]                    fault_code
);
  import cfs_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WORK  = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // configuration registers
  logic [8:0]        overvolt_limit;
  logic [8:0]        undervolt_limit;
  logic [4:0]        volt_margin;
  logic [15:0]       persist_ticks;
  logic signed [8:0] temp_trip;
  logic signed [8:0] temp_derate;
  logic signed [8:0] temp_restore;
  logic [3:0]        base_level;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      overvolt_limit  <= OVERVOLT_RST;
      undervolt_limit <= UNDERVOLT_RST;
      volt_margin     <= MARGIN_RST;
      persist_ticks   <= PERSIST_RST;
      temp_trip       <= TEMP_TRIP_RST;
      temp_derate     <= TEMP_DERATE_RST;
      temp_restore    <= TEMP_RESTORE_RST;
      base_level      <= BASE_LEVEL_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_OVERVOLT_LIMIT:  overvolt_limit  <= pwdata[8:0];
        REG_UNDERVOLT_LIMIT: undervolt_limit <= pwdata[8:0];
        REG_VOLT_MARGIN:     volt_margin     <= pwdata[4:0];
        REG_PERSIST_TICKS:   persist_ticks   <= pwdata[15:0];
        REG_TEMP_TRIP:       temp_trip       <= pwdata[8:0];
        REG_TEMP_DERATE:     temp_derate     <= pwdata[8:0];
        REG_TEMP_RESTORE:    temp_restore    <= pwdata[8:0];
        REG_BASE_LEVEL:      base_level      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback, zero extended raw bits
  always_comb begin
    case (reg_index)
      REG_OVERVOLT_LIMIT:  prdata = {23'd0, overvolt_limit};
      REG_UNDERVOLT_LIMIT: prdata = {23'd0, undervolt_limit};
      REG_VOLT_MARGIN:     prdata = {27'd0, volt_margin};
      REG_PERSIST_TICKS:   prdata = {16'd0, persist_ticks};
      REG_TEMP_TRIP:       prdata = {23'd0, temp_trip};
      REG_TEMP_DERATE:     prdata = {23'd0, temp_derate};
      REG_TEMP_RESTORE:    prdata = {23'd0, temp_restore};
      REG_BASE_LEVEL:      prdata = {28'd0, base_level};
      default:             prdata = 32'd0;
    endcase
  end

  // input register stage
  logic              s1_valid;
  logic [8:0]        s1_volts;
  logic signed [8:0] s1_temp;
  logic              s1_tcheck;
  logic              s1_sysready;
  logic              s1_start;
  logic              s1_stop;

  // stage 2 fires when a tick sits in the input register and the result slot is free or drains in this cycle
  logic advance;
  assign advance  = s1_valid && (!out_valid || out_ready);
  // the input register refills in the same cycle it drains
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_volts    <= mains_volts;
      s1_temp     <= temp_celsius;
      s1_tcheck   <= temp_check;
      s1_sysready <= system_ready;
      s1_start    <= start_charge;
      s1_stop     <= stop_charge;
    end
  end

  // supervisor state
  mode_t                 mode;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] saved_level;
  flag_t                 heat_flag;
  flag_t                 over_flag;
  flag_t                 under_flag;
  logic [TIMER_BITS-1:0] over_timer;
  logic [TIMER_BITS-1:0] under_timer;
  logic                  pwm_state;
  fault_t                last_fault;

  mode_t                 mode_next;
  logic [LEVEL_BITS-1:0] level_next;
  logic [LEVEL_BITS-1:0] saved_level_next;
  flag_t                 heat_flag_next;
  flag_t                 over_flag_next;
  flag_t                 under_flag_next;
  logic [TIMER_BITS-1:0] over_timer_next;
  logic [TIMER_BITS-1:0] under_timer_next;
  logic                  pwm_state_next;
  fault_t                last_fault_next;
  logic                  open_next;
  logic                  close_next;

  // voltage thresholds, margin added in a widened sum so that it never wraps
  logic over_high;
  logic over_clear;
  logic under_low;
  logic under_clear;
  logic over_done;
  logic under_done;

  assign over_high   = s1_volts > overvolt_limit;
  assign over_clear  = ({1'b0, s1_volts} + {5'd0, volt_margin}) <= {1'b0, overvolt_limit};
  assign under_low   = s1_volts < undervolt_limit;
  assign under_clear = {1'b0, s1_volts} >= ({1'b0, undervolt_limit} + {5'd0, volt_margin});

  always_comb begin
    mode_next        = mode;
    level_next       = level;
    saved_level_next = saved_level;
    heat_flag_next   = heat_flag;
    over_flag_next   = over_flag;
    under_flag_next  = under_flag;
    over_timer_next  = over_timer;
    under_timer_next = under_timer;
    pwm_state_next   = pwm_state;
    last_fault_next  = last_fault;
    open_next        = 1'b0;
    close_next       = 1'b0;
    over_done        = 1'b0;
    under_done       = 1'b0;

    // pending fault timers run every tick, whatever the mode
    if (over_flag == FLAG_PENDING && over_timer != TIMER_MAX) begin
      over_timer_next = over_timer + 1'b1;
    end
    if (under_flag == FLAG_PENDING && under_timer != TIMER_MAX) begin
      under_timer_next = under_timer + 1'b1;
    end

    // start acts only from idle, stop only from working
    if (mode == MODE_IDLE && s1_start) begin
      mode_next = MODE_WORK;
    end else if (mode == MODE_WORK && s1_stop) begin
      mode_next = MODE_IDLE;
    end

    // temperature check, skipped when clear and not working
    if (s1_tcheck && !(heat_flag == FLAG_CLEAR && mode_next != MODE_WORK)) begin
      if (heat_flag_next == FLAG_CLEAR && s1_temp >= temp_trip) begin
        heat_flag_next   = FLAG_PENDING;
        saved_level_next = level_next;
        open_next        = 1'b1;
        pwm_state_next   = 1'b0;
        mode_next        = MODE_PAUSE;
        last_fault_next  = FAULT_TEMP;
      end
      // derated resume, may land in the same tick as the trip
      if (heat_flag_next == FLAG_PENDING && s1_temp <= temp_derate) begin
        heat_flag_next = FLAG_LATCHED;
        close_next     = 1'b1;
        mode_next      = MODE_WORK;
        level_next     = (saved_level_next != '0) ? saved_level_next - 1'b1 : '0;
        pwm_state_next = 1'b1;
      end
      // full restore
      if (heat_flag_next != FLAG_CLEAR && s1_temp < temp_restore) begin
        heat_flag_next = FLAG_CLEAR;
        mode_next      = MODE_WORK;
        level_next     = saved_level_next;
        pwm_state_next = 1'b1;
        if (last_fault_next == FAULT_TEMP) begin
          last_fault_next = FAULT_NONE;
        end
      end
    end

    // over-voltage check
    if (s1_sysready) begin
      if (over_flag_next == FLAG_LATCHED && mode_next == MODE_PAUSE && over_clear) begin
        over_flag_next = FLAG_CLEAR;
        mode_next      = MODE_IDLE;
        pwm_state_next = 1'b1;
        if (last_fault_next == FAULT_OVER) begin
          last_fault_next = FAULT_NONE;
        end
        over_done = 1'b1;
      end
      if (!over_done && mode_next == MODE_WORK) begin
        if (over_high && over_flag_next == FLAG_CLEAR) begin
          over_flag_next  = FLAG_PENDING;
          over_timer_next = '0;
        end
        if (over_flag_next == FLAG_PENDING && over_timer_next > {1'b0, persist_ticks}) begin
          over_flag_next  = FLAG_LATCHED;
          open_next       = 1'b1;
          pwm_state_next  = 1'b0;
          mode_next       = MODE_PAUSE;
          last_fault_next = FAULT_OVER;
        end
        if (over_flag_next == FLAG_PENDING && !over_high) begin
          over_flag_next  = FLAG_CLEAR;
          over_timer_next = '0;
        end
      end
    end

    // under-voltage check
    if (s1_sysready) begin
      if (under_flag_next == FLAG_LATCHED && mode_next == MODE_PAUSE && under_clear) begin
        under_flag_next = FLAG_CLEAR;
        mode_next       = MODE_IDLE;
        pwm_state_next  = 1'b1;
        if (last_fault_next == FAULT_UNDER) begin
          last_fault_next = FAULT_NONE;
        end
        under_done = 1'b1;
      end
      if (!under_done && mode_next == MODE_WORK) begin
        if (under_low && under_flag_next == FLAG_CLEAR) begin
          under_flag_next  = FLAG_PENDING;
          under_timer_next = '0;
        end
        if (under_flag_next == FLAG_PENDING && under_timer_next > {1'b0, persist_ticks}) begin
          under_flag_next = FLAG_LATCHED;
          open_next       = 1'b1;
          pwm_state_next  = 1'b0;
          mode_next       = MODE_PAUSE;
          last_fault_next = FAULT_UNDER;
        end
        if (under_flag_next == FLAG_PENDING && !under_low) begin
          under_flag_next  = FLAG_CLEAR;
          under_timer_next = '0;
        end
      end
    end
  end

  // state and result register, written once per tick transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      level       <= LEVEL_BITS'(BASE_LEVEL_RST);
      saved_level <= '0;
      heat_flag   <= FLAG_CLEAR;
      over_flag   <= FLAG_CLEAR;
      under_flag  <= FLAG_CLEAR;
      over_timer  <= '0;
      under_timer <= '0;
      pwm_state   <= 1'b1;
      last_fault  <= FAULT_NONE;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        mode        <= mode_next;
        level       <= level_next;
        saved_level <= saved_level_next;
        heat_flag   <= heat_flag_next;
        over_flag   <= over_flag_next;
        under_flag  <= under_flag_next;
        over_timer  <= over_timer_next;
        under_timer <= under_timer_next;
        pwm_state   <= pwm_state_next;
        last_fault  <= last_fault_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the result register
  always_ff @(posedge clk) begin
    if (advance) begin
      work_state      <= mode_next;
      relay_open_cmd  <= open_next;
      relay_close_cmd <= close_next;
      pwm_enabled     <= pwm_state_next;
      current_level   <= 4'(level_next);
      fault_code      <= last_fault_next;
    end
  end

endmodule

// ===== dv/cfs_checker.sv =====
`timescale 1ns / 100ps
// checker for the charge fault supervisor: predicts every tick result and compares it
module cfs_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [8:0]                    mains_volts,
  input  logic signed [8:0]             temp_celsius,
  input  logic                          temp_check,
  input  logic                          system_ready,
  input  logic                          start_charge,
  input  logic                          stop_charge,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    work_state,
  input  logic                          relay_open_cmd,
  input  logic                          relay_close_cmd,
  input  logic                          pwm_enabled,
  input  logic [3:0]                    current_level,
  input  logic [1:0]                    fault_code,
  output int                            fail_count,
  output int                            outstanding,
  output int                            n_results,
  output int                            n_trips,
  output int                            n_resumes
);
  import cfs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WORK  = 2'd1,
    ST_PAUSE = 2'd2
  } work_mode_t;

  typedef struct packed {
    logic [1:0] ws;
    logic       open_cmd;
    logic       close_cmd;
    logic       pwm;
    logic [3:0] lvl;
    logic [1:0] fault;
  } tick_result_t;

  // register copies
  logic [8:0]        ov_lim, uv_lim;
  logic [4:0]        margin;
  logic [15:0]       persist;
  logic signed [8:0] t_trip, t_derate, t_restore;
  logic [3:0]        base_lvl;

  // supervisor state
  work_mode_t            mode;
  logic [LEVEL_BITS-1:0] lvl, saved_lvl;
  flag_t                 heat_flag, over_flag, under_flag;
  logic [TIMER_BITS-1:0] over_tmr, under_tmr;
  logic                  pwm_on;
  fault_t                last_fault;

  tick_result_t tick_results_q[$];
  int errs = 0;
  int seen = 0;
  int opens = 0;
  int closes = 0;

  function automatic void enter_pause(fault_t code);
    pwm_on     = 1'b0;
    mode       = ST_PAUSE;
    last_fault = code;
  endfunction

  function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // expected read value of a register and the bits that carry it
  function automatic logic [31:0] reg_image(input logic [2:0] idx, output logic [31:0] mask);
    logic [31:0] img;
    img  = '0;
    mask = '0;
    case (idx)
      REG_OVERVOLT_LIMIT:  begin img = 32'(ov_lim);    mask = 32'h1FF;  end
      REG_UNDERVOLT_LIMIT: begin img = 32'(uv_lim);    mask = 32'h1FF;  end
      REG_VOLT_MARGIN:     begin img = 32'(margin);    mask = 32'h1F;   end
      REG_PERSIST_TICKS:   begin img = 32'(persist);   mask = 32'hFFFF; end
      REG_TEMP_TRIP:       begin img = {23'b0, t_trip};    mask = 32'h1FF; end
      REG_TEMP_DERATE:     begin img = {23'b0, t_derate};  mask = 32'h1FF; end
      REG_TEMP_RESTORE:    begin img = {23'b0, t_restore}; mask = 32'h1FF; end
      REG_BASE_LEVEL:      begin img = 32'(base_lvl);  mask = 32'hF;    end
      default: ;
    endcase
    return img;
  endfunction

  // one millisecond tick of the supervisor
  task automatic advance_tick(input logic [8:0] v_in, input logic signed [8:0] t_in,
                              input logic tchk, input logic rdy, input logic go,
                              input logic halt, output tick_result_t r);
    int   volts, temp;
    logic open_c, close_c, done;
    volts   = int'(v_in);
    temp    = int'(t_in);
    open_c  = 1'b0;
    close_c = 1'b0;

    // pending fault timers run on every tick, saturating
    if (over_flag == FLAG_PENDING && over_tmr != '1) over_tmr++;
    if (under_flag == FLAG_PENDING && under_tmr != '1) under_tmr++;

    if (mode == ST_IDLE && go) mode = ST_WORK;
    else if (mode == ST_WORK && halt) mode = ST_IDLE;

    // temperature
    if (tchk && !(heat_flag == FLAG_CLEAR && mode != ST_WORK)) begin
      if (heat_flag == FLAG_CLEAR && temp >= int'(t_trip)) begin
        heat_flag = FLAG_PENDING;
        saved_lvl = lvl;
        enter_pause(FAULT_TEMP);
        open_c = 1'b1;
      end
      if (heat_flag == FLAG_PENDING && temp <= int'(t_derate)) begin
        heat_flag = FLAG_LATCHED;
        close_c   = 1'b1;
        mode      = ST_WORK;
        lvl       = (saved_lvl != '0) ? saved_lvl - 1'b1 : '0;
        pwm_on    = 1'b1;
      end
      if (heat_flag != FLAG_CLEAR && temp < int'(t_restore)) begin
        heat_flag = FLAG_CLEAR;
        mode      = ST_WORK;
        lvl       = saved_lvl;
        pwm_on    = 1'b1;
        if (last_fault == FAULT_TEMP) last_fault = FAULT_NONE;
      end
    end

    // over-voltage
    if (rdy) begin
      done = 1'b0;
      if (over_flag == FLAG_LATCHED && mode == ST_PAUSE &&
          volts <= int'(ov_lim) - int'(margin)) begin
        over_flag = FLAG_CLEAR;
        mode      = ST_IDLE;
        pwm_on    = 1'b1;
        if (last_fault == FAULT_OVER) last_fault = FAULT_NONE;
        done = 1'b1;
      end
      if (!done && mode == ST_WORK) begin
        if (volts > int'(ov_lim) && over_flag == FLAG_CLEAR) begin
          over_flag = FLAG_PENDING;
          over_tmr  = '0;
        end
        if (over_flag == FLAG_PENDING && over_tmr > TIMER_BITS'(persist)) begin
          over_flag = FLAG_LATCHED;
          enter_pause(FAULT_OVER);
          open_c = 1'b1;
        end
        if (over_flag == FLAG_PENDING && volts <= int'(ov_lim)) begin
          over_flag = FLAG_CLEAR;
          over_tmr  = '0;
        end
      end
    end

    // under-voltage
    if (rdy) begin
      done = 1'b0;
      if (under_flag == FLAG_LATCHED && mode == ST_PAUSE &&
          volts >= int'(uv_lim) + int'(margin)) begin
        under_flag = FLAG_CLEAR;
        mode       = ST_IDLE;
        pwm_on     = 1'b1;
        if (last_fault == FAULT_UNDER) last_fault = FAULT_NONE;
        done = 1'b1;
      end
      if (!done && mode == ST_WORK) begin
        if (volts < int'(uv_lim) && under_flag == FLAG_CLEAR) begin
          under_flag = FLAG_PENDING;
          under_tmr  = '0;
        end
        if (under_flag == FLAG_PENDING && under_tmr > TIMER_BITS'(persist)) begin
          under_flag = FLAG_LATCHED;
          enter_pause(FAULT_UNDER);
          open_c = 1'b1;
        end
        if (under_flag == FLAG_PENDING && volts >= int'(uv_lim)) begin
          under_flag = FLAG_CLEAR;
          under_tmr  = '0;
        end
      end
    end

    r.ws        = mode;
    r.open_cmd  = open_c;
    r.close_cmd = close_c;
    r.pwm       = pwm_on;
    r.lvl       = 4'(lvl);
    r.fault     = last_fault;
  endtask

  always @(posedge clk) begin
    tick_result_t fresh, want, got;
    logic [31:0]  img, mask;
    if (rst) begin
      ov_lim     = OVERVOLT_RST;
      uv_lim     = UNDERVOLT_RST;
      margin     = MARGIN_RST;
      persist    = PERSIST_RST;
      t_trip     = TEMP_TRIP_RST;
      t_derate   = TEMP_DERATE_RST;
      t_restore  = TEMP_RESTORE_RST;
      base_lvl   = BASE_LEVEL_RST;
      mode       = ST_IDLE;
      lvl        = LEVEL_BITS'(BASE_LEVEL_RST);
      saved_lvl  = '0;
      heat_flag  = FLAG_CLEAR;
      over_flag  = FLAG_CLEAR;
      under_flag = FLAG_CLEAR;
      over_tmr   = '0;
      under_tmr  = '0;
      pwm_on     = 1'b1;
      last_fault = FAULT_NONE;
      tick_results_q.delete();
    end else begin
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_BITS-1:2])
            REG_OVERVOLT_LIMIT:  ov_lim    = pwdata[8:0];
            REG_UNDERVOLT_LIMIT: uv_lim    = pwdata[8:0];
            REG_VOLT_MARGIN:     margin    = pwdata[4:0];
            REG_PERSIST_TICKS:   persist   = pwdata[15:0];
            REG_TEMP_TRIP:       t_trip    = pwdata[8:0];
            REG_TEMP_DERATE:     t_derate  = pwdata[8:0];
            REG_TEMP_RESTORE:    t_restore = pwdata[8:0];
            REG_BASE_LEVEL:      base_lvl  = pwdata[3:0];
            default: ;
          endcase
        end else begin
          img = reg_image(paddr[ADDR_BITS-1:2], mask);
          if ((prdata & mask) !== img) begin
            errs++;
            $display("%0t ns: register %0d readback, expected 0x%0h, got 0x%0h",
                     $time, paddr[ADDR_BITS-1:2], img, prdata & mask);
          end
        end
      end

      // result side first, a tick never comes out in the cycle it goes in
      if (out_valid && out_ready) begin
        got = '{work_state, relay_open_cmd, relay_close_cmd, pwm_enabled,
                current_level, fault_code};
        if (tick_results_q.size() == 0) begin
          errs++;
          $display("%0t ns: result with no tick waiting, expected none, got 0x%0h",
                   $time, got);
        end else begin
          want = tick_results_q.pop_front();
          check_field("work_state", want.ws, got.ws);
          check_field("relay_open_cmd", want.open_cmd, got.open_cmd);
          check_field("relay_close_cmd", want.close_cmd, got.close_cmd);
          check_field("pwm_enabled", want.pwm, got.pwm);
          check_field("current_level", want.lvl, got.lvl);
          check_field("fault_code", want.fault, got.fault);
        end
        seen++;
        if (relay_open_cmd === 1'b1) opens++;
        if (relay_close_cmd === 1'b1) closes++;
      end

      if (in_valid && in_ready) begin
        advance_tick(mains_volts, temp_celsius, temp_check, system_ready,
                     start_charge, stop_charge, fresh);
        tick_results_q.push_back(fresh);
      end
    end
    fail_count  <= errs;
    outstanding <= tick_results_q.size();
    n_results   <= seen;
    n_trips     <= opens;
    n_resumes   <= closes;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for the charge fault supervisor: tick stimulus, register programming, verdict
module tb_top;
  import cfs_pkg::*;

  // stimulus sizing
  localparam int PHASE_TICKS   = 100;
  localparam int SOAK_TICKS    = 40;      // idle ticks that run a pending timer past persistence
  localparam int HOLD_CYCLES   = 64;      // long receiver hold-off to back up the pipe
  localparam int SETTLE_CYCLES = 4;       // extra quiet cycles after the last expected result

  typedef enum int {
    CFG_NOMINAL,
    CFG_SOAK,
    CFG_TYPICAL,
    CFG_LOW_EXTREME,
    CFG_HIGH_EXTREME,
    CFG_OVERLAP
  } cfg_kind_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_STALL,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    V_NOMINAL,
    V_HIGH,
    V_LOW,
    V_EDGE,
    V_ANY
  } volts_regime_t;

  localparam cfg_kind_t PHASE_KIND [8] = '{CFG_TYPICAL, CFG_LOW_EXTREME, CFG_TYPICAL,
                                           CFG_HIGH_EXTREME, CFG_OVERLAP, CFG_TYPICAL,
                                           CFG_TYPICAL, CFG_OVERLAP};

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb port
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // tick channel
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [8:0]        mains_volts  = '0;
  logic signed [8:0] temp_celsius = '0;
  logic              temp_check   = 1'b0;
  logic              system_ready = 1'b0;
  logic              start_charge = 1'b0;
  logic              stop_charge  = 1'b0;

  // result channel
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] work_state;
  logic       relay_open_cmd;
  logic       relay_close_cmd;
  logic       pwm_enabled;
  logic [3:0] current_level;
  logic [1:0] fault_code;

  // from the checker
  int fail_count;
  int outstanding;
  int n_results;
  int n_trips;
  int n_resumes;

  // register values the stimulus currently aims at
  logic [8:0]        cfg_ov, cfg_uv;
  logic [4:0]        cfg_margin;
  logic [15:0]       cfg_persist;
  logic signed [8:0] cfg_trip, cfg_derate, cfg_restore;
  logic [3:0]        cfg_base;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // receiver hold-off, armed once by the stimulus
  logic hold_arm  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // mains voltage runs in regimes so that faults can persist long enough to trip
  volts_regime_t regime      = V_NOMINAL;
  int            regime_left = 0;

  int n_settings = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  charge_fault_supervisor u_top (.*);

  cfs_checker u_chk (.*);

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end
  end

  function automatic int clamp(int x, int lo, int hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic [31:0] cfg_word(input logic [2:0] idx);
    case (idx)
      REG_OVERVOLT_LIMIT:  return 32'(cfg_ov);
      REG_UNDERVOLT_LIMIT: return 32'(cfg_uv);
      REG_VOLT_MARGIN:     return 32'(cfg_margin);
      REG_PERSIST_TICKS:   return 32'(cfg_persist);
      REG_TEMP_TRIP:       return {23'b0, cfg_trip};
      REG_TEMP_DERATE:     return {23'b0, cfg_derate};
      REG_TEMP_RESTORE:    return {23'b0, cfg_restore};
      REG_BASE_LEVEL:      return 32'(cfg_base);
      default:             return '0;
    endcase
  endfunction

  // one apb transaction, setup then access, then the bus returns to idle
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // choose a register setting, write every register and read all of them back
  task automatic program_config(input cfg_kind_t kind);
    int t;
    case (kind)
      CFG_NOMINAL, CFG_SOAK: begin
        cfg_ov      = 9'd265;
        cfg_uv      = 9'd100;
        cfg_margin  = 5'd2;
        cfg_persist = (kind == CFG_SOAK) ? 16'd20 : 16'd2;
        cfg_trip    = 9'sd80;
        cfg_derate  = 9'sd75;
        cfg_restore = 9'sd70;
        cfg_base    = 4'd5;
      end
      CFG_LOW_EXTREME: begin
        // temperature trips at once, voltage faults after one more tick, and no voltage fault can ever clear
        cfg_ov      = 9'd0;
        cfg_uv      = 9'd511;
        cfg_margin  = 5'd31;
        cfg_persist = 16'd0;
        cfg_trip    = -9'sd40;
        cfg_derate  = 9'sd150;
        cfg_restore = -9'sd40;
        cfg_base    = 4'd15;
      end
      CFG_HIGH_EXTREME: begin
        // voltage faults never start, any cooling restores at once
        cfg_ov      = 9'd511;
        cfg_uv      = 9'd0;
        cfg_margin  = 5'd0;
        cfg_persist = 16'hFFFF;
        cfg_trip    = 9'sd150;
        cfg_derate  = -9'sd40;
        cfg_restore = 9'sd150;
        cfg_base    = 4'd0;
      end
      CFG_OVERLAP: begin
        // derate at or above trip so a single check can trip and resume
        cfg_ov      = 9'($urandom_range(230, 290));
        cfg_uv      = 9'($urandom_range(60, 120));
        cfg_margin  = 5'($urandom_range(0, 31));
        cfg_persist = 16'($urandom_range(0, 12));
        t           = int'($urandom_range(40, 80));
        cfg_trip    = 9'(t);
        cfg_derate  = 9'(t + int'($urandom_range(0, 20)));
        cfg_restore = 9'(t - int'($urandom_range(0, 20)));
        cfg_base    = 4'($urandom_range(0, 15));
      end
      default: begin
        cfg_ov      = 9'($urandom_range(230, 290));
        cfg_uv      = 9'($urandom_range(60, 120));
        cfg_margin  = 5'($urandom_range(0, 31));
        cfg_persist = 16'($urandom_range(0, 12));
        t           = int'($urandom_range(50, 110));
        cfg_trip    = 9'(t);
        t           = t - int'($urandom_range(0, 10));
        cfg_derate  = 9'(t);
        cfg_restore = 9'(t - int'($urandom_range(0, 10)));
        cfg_base    = 4'($urandom_range(0, 15));
      end
    endcase
    for (int i = REG_OVERVOLT_LIMIT; i <= REG_BASE_LEVEL; i++)
      apb_access(1'b1, 3'(i), cfg_word(3'(i)));
    for (int i = REG_OVERVOLT_LIMIT; i <= REG_BASE_LEVEL; i++)
      apb_access(1'b0, 3'(i), '0);
    n_settings++;
  endtask

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_SEND:  begin send_idle_pct = 54; stall_pct = 0;  end
      IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 54; end
      IDLE_BOTH:  begin send_idle_pct = 26; stall_pct = 26; end
      default:    begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // offer one tick transaction and hold it until it is taken
  task automatic send_tick(input logic [8:0] v, input logic signed [8:0] t,
                           input logic tchk, input logic rdy, input logic go,
                           input logic halt);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mains_volts  <= v;
    temp_celsius <= t;
    temp_check   <= tchk;
    system_ready <= rdy;
    start_charge <= go;
    stop_charge  <= halt;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, let every expected result come out, then a few cycles more
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_volts();
    int ov, uv, mg, lo, hi, pivot;
    ov = int'(cfg_ov);
    uv = int'(cfg_uv);
    mg = int'(cfg_margin);
    if (regime_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: regime = V_NOMINAL;
        4, 5:       regime = V_HIGH;
        6, 7:       regime = V_LOW;
        8:          regime = V_EDGE;
        default:    regime = V_ANY;
      endcase
      // long enough, now and then, to outlast the persistence time
      regime_left = int'($urandom_range(1, (cfg_persist > 16'd34) ? 40 : int'(cfg_persist) + 6));
    end
    regime_left--;
    case (regime)
      V_NOMINAL: begin
        lo = uv + mg;
        hi = ov - mg;
        if (lo <= hi) return lo + int'($urandom_range(0, hi - lo));
        return int'($urandom_range(0, 511));
      end
      V_HIGH: return (ov >= 511) ? 511 : ov + 1 + int'($urandom_range(0, 510 - ov));
      V_LOW:  return (uv == 0) ? 0 : int'($urandom_range(0, uv - 1));
      V_EDGE: begin
        // straddle a limit and its hysteresis band
        pivot = $urandom_range(0, 1) ? ov : uv;
        return clamp(pivot - mg - 2 + int'($urandom_range(0, 2 * mg + 4)), 0, 511);
      end
      default: return int'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic int pick_temp();
    int t;
    case ($urandom_range(0, 9))
      0, 1, 2: t = int'($urandom_range(0, 190)) - 40;
      3, 4, 5: begin
        // near one of the three temperature thresholds
        case ($urandom_range(0, 2))
          0:       t = int'(cfg_trip);
          1:       t = int'(cfg_derate);
          default: t = int'(cfg_restore);
        endcase
        t = t + int'($urandom_range(0, 6)) - 3;
      end
      default: t = int'(cfg_restore) - 1 - int'($urandom_range(0, 30));
    endcase
    return clamp(t, -40, 150);
  endfunction

  task automatic random_tick();
    logic tchk, rdy, go, halt;
    tchk = (int'($urandom_range(0, 99)) < 30);
    rdy  = (int'($urandom_range(0, 99)) < 90);
    go   = (int'($urandom_range(0, 99)) < 20);
    halt = (int'($urandom_range(0, 99)) < 6);
    send_tick(9'(pick_volts()), 9'(pick_temp()), tchk, rdy, go, halt);
  endtask

  // main stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed ticks with short persistence so every path is reached quickly
    set_idling(IDLE_NONE);
    program_config(CFG_NOMINAL);
    send_tick(9'd230, 9'sd150, 1'b1, 1'b1, 1'b0, 1'b0);  // hot while idle, check skipped
    send_tick(9'd230, 9'sd25,  1'b0, 1'b1, 1'b1, 1'b1);  // start and stop from idle
    send_tick(9'd230, 9'sd25,  1'b0, 1'b1, 1'b1, 1'b1);  // start and stop from working
    send_tick(9'd230, 9'sd25,  1'b1, 1'b1, 1'b1, 1'b0);  // working, cool check
    repeat (4)                                           // over-voltage persists and trips
      send_tick(9'd300, 9'sd25, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(9'd264, 9'sd25,  1'b0, 1'b1, 1'b1, 1'b1);  // inside margin, requests ignored
    send_tick(9'd263, 9'sd25,  1'b0, 1'b1, 1'b0, 1'b0);  // clears back to idle
    send_tick(9'd0,   9'sd25,  1'b0, 1'b1, 1'b1, 1'b0);  // start at zero volts
    repeat (3)                                           // under-voltage trips
      send_tick(9'd0, 9'sd25, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(9'd101, 9'sd25,  1'b0, 1'b1, 1'b0, 1'b0);  // inside margin
    send_tick(9'd511, 9'sd25,  1'b0, 1'b1, 1'b0, 1'b0);  // clears back to idle
    send_tick(9'd230, 9'sd150, 1'b1, 1'b1, 1'b1, 1'b0);  // over-temperature trips at once
    send_tick(9'd230, 9'sd75,  1'b1, 1'b1, 1'b0, 1'b0);  // derated resume, level floored
    send_tick(9'd230, -9'sd40, 1'b1, 1'b1, 1'b0, 1'b0);  // full restore, fault cleared
    send_tick(9'd511, 9'sd25,  1'b0, 1'b0, 1'b0, 1'b0);  // voltage checks disabled
    send_tick(9'd230, 9'sd25,  1'b0, 1'b1, 1'b0, 1'b1);  // stop
    wait_quiet();

    // soak: a pending over-voltage timer keeps counting in idle past the persistence
    // time, then a restart finds the fault overdue and trips at once
    program_config(CFG_SOAK);
    send_tick(9'd300, 9'sd25, 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(9'd300, 9'sd25, 1'b0, 1'b1, 1'b0, 1'b1);
    repeat (SOAK_TICKS) send_tick(9'd300, 9'sd25, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(9'd300, 9'sd25, 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(9'd200, 9'sd25, 1'b0, 1'b1, 1'b0, 1'b0);
    wait_quiet();

    // random phases, each with its own setting and idling pattern
    for (int p = 0; p < $size(PHASE_KIND); p++) begin
      program_config(PHASE_KIND[p]);
      set_idling(idle_mode_t'(p % 4));
      if (p == 0) hold_arm = 1'b1;  // sender keeps offering while the receiver holds off
      repeat (PHASE_TICKS) random_tick();
      wait_quiet();
    end

    $display("covered %0d tick results over %0d register settings, incl. a timer soak",
             n_results, n_settings);
    $display("relay opened %0d times, derated resumptions %0d", n_trips, n_resumes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cfs_pkg.sv
rtl/charge_fault_supervisor.sv
dv/cfs_checker.sv
dv/tb_top.sv
